// ----- rtl/core/stlw_pkg.sv -----
// Shared types and constants for the structure table length walker.
// No dependencies; imported by stlw_walker, structure_table_length_walker and both tb files.
package stlw_pkg;

   localparam int OFF_WIDTH       = 17;
   localparam int CNT_WIDTH       = 16;
   localparam int REG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [7:0] END_TYPE = 8'h7F;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TBL_LEN          = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECLARED_STRUCTS = 2'd1;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_BODY,
      PH_SCAN
   } phase_type;

   typedef struct packed {
      logic                 done_res;
      logic [OFF_WIDTH-1:0] real_length;
      logic [CNT_WIDTH-1:0] struct_count;
      logic                 count_mismatch;
      logic                 no_end_marker;
      logic                 length_mismatch;
   } walk_result_type;

   typedef struct packed {
      logic      finished;
      phase_type phase;
   } walk_status_type;

endpackage

// ----- rtl/core/stlw_walker.sv -----
// Walker state registers and the per-byte step logic.
// Depends on stlw_pkg.
module stlw_walker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic [7:0]                       table_byte,
   input  logic [stlw_pkg::REG_WIDTH-1:0]   tbl_len,
   input  logic [stlw_pkg::REG_WIDTH-1:0]   declared_structs,
   output stlw_pkg::walk_result_type        result,
   output stlw_pkg::walk_status_type        status
);
   import stlw_pkg::*;

   logic [OFF_WIDTH-1:0] offset_ff, offset_in;
   logic [OFF_WIDTH-1:0] target_ff, target_in;
   logic [OFF_WIDTH-1:0] start_ff, start_in;
   phase_type            phase_ff, phase_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 end_seen_ff, end_seen_in;
   logic                 prev_zero_ff, prev_zero_in;
   logic                 finished_ff, finished_in;

   logic                 fin;
   logic [OFF_WIDTH-1:0] fin_off;
   logic [CNT_WIDTH-1:0] count_inc;
   logic [7:0]           body_len;
   logic [OFF_WIDTH-1:0] body_end;
   logic [OFF_WIDTH-1:0] tl_ext;
   logic                 byte_zero;

   assign tl_ext    = {{(OFF_WIDTH-REG_WIDTH){1'b0}}, tbl_len};
   assign count_inc = count_ff + 1'b1;
   assign body_len  = (table_byte < 8'd2) ? 8'd2 : table_byte;
   assign body_end  = start_ff + {{(OFF_WIDTH-8){1'b0}}, body_len};
   assign byte_zero = (table_byte == 8'd0);

   // next state
   always_comb begin
      offset_in    = offset_ff;
      target_in    = target_ff;
      start_in     = start_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      end_seen_in  = end_seen_ff;
      prev_zero_in = prev_zero_ff;
      finished_in  = finished_ff;
      fin          = 1'b0;
      fin_off      = '0;
      if (!finished_ff) begin
         unique case (phase_ff)
            PH_LEN: begin
               offset_in = offset_ff + 1'b1;
               if (body_end >= tl_ext) begin
                  // body runs to table end: no string area read
                  fin     = 1'b1;
                  fin_off = body_end + 17'd2;
               end else begin
                  target_in = body_end;
                  phase_in  = PH_BODY;
               end
            end
            PH_BODY: begin
               offset_in = offset_ff + 1'b1;
               if (offset_ff == target_ff) begin
                  prev_zero_in = byte_zero;
                  phase_in     = PH_SCAN;
               end
            end
            PH_SCAN: begin
               offset_in = offset_ff + 1'b1;
               if (prev_zero_ff && byte_zero) begin
                  fin     = 1'b1;
                  fin_off = offset_ff + 1'b1;
               end else if (offset_ff >= tl_ext) begin
                  fin     = 1'b1;
                  fin_off = offset_ff + 17'd2;
               end else begin
                  prev_zero_in = byte_zero;
               end
            end
            default: begin
               // structure start; the byte is not consumed if the walk cannot start
               if (offset_ff > tl_ext || count_ff >= declared_structs) begin
                  finished_in = 1'b1;
               end else begin
                  if (table_byte == END_TYPE)
                     end_seen_in = 1'b1;
                  offset_in = offset_ff + 1'b1;
                  phase_in  = PH_LEN;
               end
            end
         endcase
         if (fin) begin
            start_in = fin_off;
            count_in = count_inc;
            phase_in = PH_TYPE;
            if (end_seen_ff || fin_off > tl_ext || count_inc >= declared_structs)
               finished_in = 1'b1;
         end
      end
   end

   // result word, taken from the state after this byte
   always_comb begin
      result.done_res        = finished_in;
      result.real_length     = start_in;
      result.struct_count    = count_in;
      result.count_mismatch  = finished_in && (count_in != declared_structs);
      result.no_end_marker   = finished_in && !end_seen_in;
      result.length_mismatch = finished_in && (start_in != tl_ext);
      status.finished        = finished_ff;
      status.phase           = phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         target_ff    <= '0;
         start_ff     <= '0;
         phase_ff     <= PH_TYPE;
         count_ff     <= '0;
         end_seen_ff  <= 1'b0;
         prev_zero_ff <= 1'b0;
         finished_ff  <= 1'b0;
      end else if (step_en) begin
         offset_ff    <= offset_in;
         target_ff    <= target_in;
         start_ff     <= start_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         end_seen_ff  <= end_seen_in;
         prev_zero_ff <= prev_zero_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// ----- rtl/core/structure_table_length_walker.sv -----
// Top level: input register, configuration registers, walker and result register.
// Depends on stlw_pkg and stlw_walker.
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_valid/req_ready   | table_byte (8)
//   rsp_     | out       | rsp_valid/rsp_ready   | done, length, count, 3 warnings
//   csr_     | in        | csr_write_enable      | csr_index, csr_wdata (16)
//
// One byte per cycle sustained while rsp_ is not stalled; a taken byte passes the input
// register, then the walker step into the result register, before its word is on rsp_
// and can be accepted.
// Synchronous active-high reset clears the walk and both registers.
// A stalled rsp_ readies back through the input register; neither side bubbles.
module structure_table_length_walker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_table_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_done_res,
   output logic [stlw_pkg::OFF_WIDTH-1:0]       rsp_real_length,
   output logic [stlw_pkg::CNT_WIDTH-1:0]       rsp_struct_count,
   output logic                                 rsp_count_mismatch,
   output logic                                 rsp_no_end_marker,
   output logic                                 rsp_length_mismatch,
   input  logic                                 csr_write_enable,
   input  logic [stlw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [stlw_pkg::REG_WIDTH-1:0]       csr_wdata
);
   import stlw_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   walk_result_type      out_word_ff;
   logic [REG_WIDTH-1:0] tbl_len_ff, tbl_len_in;
   logic [REG_WIDTH-1:0] declared_ff, declared_in;

   logic                 out_free;
   logic                 advance;
   logic                 take_in;
   walk_result_type      step_result;
   walk_status_type      walk_status;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign take_in   = req_valid && req_ready;

   assign in_valid_in  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_comb begin
      tbl_len_in  = tbl_len_ff;
      declared_in = declared_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_TBL_LEN:          tbl_len_in  = csr_wdata;
            REG_DECLARED_STRUCTS: declared_in = csr_wdata;
            default: ;
         endcase
      end
   end

   stlw_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .table_byte       (in_byte_ff),
      .tbl_len          (tbl_len_ff),
      .declared_structs (declared_ff),
      .result           (step_result),
      .status           (walk_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tbl_len_ff   <= '0;
         declared_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         tbl_len_ff   <= tbl_len_in;
         declared_ff  <= declared_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in)
         in_byte_ff <= req_table_byte;
      if (advance)
         out_word_ff <= step_result;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_done_res        = out_word_ff.done_res;
   assign rsp_real_length     = out_word_ff.real_length;
   assign rsp_struct_count    = out_word_ff.struct_count;
   assign rsp_count_mismatch  = out_word_ff.count_mismatch;
   assign rsp_no_end_marker   = out_word_ff.no_end_marker;
   assign rsp_length_mismatch = out_word_ff.length_mismatch;

   // once ended, the walk stays ended until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      walk_status.finished |=> walk_status.finished)
      else $error("walk left the finished state");

   // a finished walk always parks at a structure start
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      walk_status.finished |-> walk_status.phase == PH_TYPE)
      else $error("finished walk not at structure start");

   // warnings only ride on a done word
   a_warn_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (rsp_count_mismatch || rsp_no_end_marker || rsp_length_mismatch)
      |-> rsp_done_res)
      else $error("warning flag without done");

   // an accepted word is held in the input register next cycle
   a_take_held: assert property (@(posedge clock) disable iff (reset)
      take_in |=> in_valid_ff)
      else $error("accepted word lost");

endmodule

// ----- tb/structure_table_length_walker_checker.sv -----
`timescale 1ns / 1ps
// Checker for structure_table_length_walker. It tracks the table walk byte by byte and
// compares every rsp_ word with the status queued for its byte.
// Depends on stlw_pkg only.
module structure_table_length_walker_checker
   import stlw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_table_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_done_res,
   input  logic [OFF_WIDTH-1:0]       rsp_real_length,
   input  logic [CNT_WIDTH-1:0]       rsp_struct_count,
   input  logic                       rsp_count_mismatch,
   input  logic                       rsp_no_end_marker,
   input  logic                       rsp_length_mismatch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]       csr_wdata,
   output int                         mismatch_count,
   output int                         pending_words
);

   walk_result_type expected_status[$];
   int unsigned     words_checked;

   // shadow registers and walk state
   logic [REG_WIDTH-1:0] tbl_len_q;
   logic [REG_WIDTH-1:0] declared_q;
   logic [OFF_WIDTH-1:0] offset_q;
   logic [OFF_WIDTH-1:0] target_q;
   logic [OFF_WIDTH-1:0] start_q;
   phase_type            phase_q;
   logic [CNT_WIDTH-1:0] count_q;
   logic                 end_seen_q;
   logic                 prev_zero_q;
   logic                 finished_q;

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("word %0d: %s is %0h, expected %0h", words_checked, field, got, want);
      mismatch_count++;
   endtask

   task automatic close_structure(input logic [OFF_WIDTH-1:0] end_offset);
      start_q = end_offset;
      count_q = count_q + 1'b1;
      phase_q = PH_TYPE;
      if (end_seen_q || start_q > tbl_len_q || count_q >= declared_q)
         finished_q = 1'b1;
   endtask

   task automatic walk_byte(input logic [7:0] b);
      logic [OFF_WIDTH-1:0] here;
      logic [OFF_WIDTH-1:0] body_end;
      here = offset_q;
      // lengths below 2 count as 2
      body_end = start_q + ((b < 8'd2) ? 8'd2 : b);
      if (!finished_q) begin
         case (phase_q)
            PH_LEN: begin
               offset_q = here + 1'b1;
               if (body_end >= tbl_len_q) begin
                  close_structure(body_end + 2'd2);
               end else begin
                  target_q = body_end;
                  phase_q  = PH_BODY;
               end
            end
            PH_BODY: begin
               offset_q = here + 1'b1;
               // first string byte is taken here and primes the zero tracker
               if (here == target_q) begin
                  prev_zero_q = (b == 8'h00);
                  phase_q     = PH_SCAN;
               end
            end
            PH_SCAN: begin
               offset_q = here + 1'b1;
               if (prev_zero_q && b == 8'h00)
                  close_structure(here + 1'b1);
               else if (here >= tbl_len_q)
                  close_structure(here + 2'd2);
               else
                  prev_zero_q = (b == 8'h00);
            end
            default: begin
               // walk cannot start: byte is not consumed
               if (here > tbl_len_q || count_q >= declared_q) begin
                  finished_q = 1'b1;
               end else begin
                  if (b == END_TYPE)
                     end_seen_q = 1'b1;
                  offset_q = here + 1'b1;
                  phase_q  = PH_LEN;
               end
            end
         endcase
      end
   endtask

   function automatic walk_result_type walk_status();
      walk_result_type r;
      r.done_res        = finished_q;
      r.real_length     = start_q;
      r.struct_count    = count_q;
      r.count_mismatch  = finished_q && (count_q != declared_q);
      r.no_end_marker   = finished_q && !end_seen_q;
      r.length_mismatch = finished_q && (start_q != tbl_len_q);
      return r;
   endfunction

   task automatic check_word(input walk_result_type got);
      walk_result_type want;
      if (expected_status.size() == 0) begin
         report_mismatch("unexpected word", got, 0);
      end else begin
         want = expected_status.pop_front();
         if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
         if (got.real_length !== want.real_length)
            report_mismatch("real_length", got.real_length, want.real_length);
         if (got.struct_count !== want.struct_count)
            report_mismatch("struct_count", got.struct_count, want.struct_count);
         if (got.count_mismatch !== want.count_mismatch)
            report_mismatch("count_mismatch", got.count_mismatch, want.count_mismatch);
         if (got.no_end_marker !== want.no_end_marker)
            report_mismatch("no_end_marker", got.no_end_marker, want.no_end_marker);
         if (got.length_mismatch !== want.length_mismatch)
            report_mismatch("length_mismatch", got.length_mismatch, want.length_mismatch);
      end
      words_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tbl_len_q      = '0;
         declared_q     = '0;
         offset_q       = '0;
         target_q       = '0;
         start_q        = '0;
         phase_q        = PH_TYPE;
         count_q        = '0;
         end_seen_q     = 1'b0;
         prev_zero_q    = 1'b0;
         finished_q     = 1'b0;
         words_checked  = 0;
         mismatch_count = 0;
         expected_status.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_TBL_LEN:          tbl_len_q  = csr_wdata;
               REG_DECLARED_STRUCTS: declared_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready)
            check_word({rsp_done_res, rsp_real_length, rsp_struct_count,
                        rsp_count_mismatch, rsp_no_end_marker, rsp_length_mismatch});
         if (req_valid && req_ready) begin
            walk_byte(req_table_byte);
            expected_status.push_back(walk_status());
         end
      end
      pending_words = expected_status.size();
   end

endmodule

// ----- tb/structure_table_length_walker_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for structure_table_length_walker: feeds structure tables and register
// writes, paces the rsp_ side and prints the verdict.
// Depends on stlw_pkg, structure_table_length_walker and structure_table_length_walker_checker.
module structure_table_length_walker_tb;
   import stlw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BYTES = 180;

   typedef enum int {
      END_BY_MARKER,
      END_BY_COUNT,
      END_BY_ZERO_COUNT,
      END_BY_SHORT_TABLE,
      END_BY_BODY,
      END_BY_SCAN
   } walk_ending_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_table_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_done_res;
   logic [OFF_WIDTH-1:0]       rsp_real_length;
   logic [CNT_WIDTH-1:0]       rsp_struct_count;
   logic                       rsp_count_mismatch;
   logic                       rsp_no_end_marker;
   logic                       rsp_length_mismatch;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0]       csr_wdata = '0;

   int          mismatch_count;
   int          pending_words;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_request = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned structs_sent = 0;

   logic [OFF_WIDTH-1:0] seen_real_length = '0;
   logic [CNT_WIDTH-1:0] seen_struct_count = '0;

   // four short structures: zero and all-ones bytes, lengths 0, 1, 5, 2,
   // end type value inside body and string area
   logic [7:0] opening_table [22] = '{
      8'h00, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'h01, 8'hFF, 8'h00, 8'h00,
      8'h80, 8'h05, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'h00,
      8'h01, 8'h02, 8'h7F, 8'h01, 8'h00, 8'h00
   };

   structure_table_length_walker u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_table_byte      (req_table_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_done_res        (rsp_done_res),
      .rsp_real_length     (rsp_real_length),
      .rsp_struct_count    (rsp_struct_count),
      .rsp_count_mismatch  (rsp_count_mismatch),
      .rsp_no_end_marker   (rsp_no_end_marker),
      .rsp_length_mismatch (rsp_length_mismatch),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   structure_table_length_walker_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_table_byte      (req_table_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_done_res        (rsp_done_res),
      .rsp_real_length     (rsp_real_length),
      .rsp_struct_count    (rsp_struct_count),
      .rsp_count_mismatch  (rsp_count_mismatch),
      .rsp_no_end_marker   (rsp_no_end_marker),
      .rsp_length_mismatch (rsp_length_mismatch),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .pending_words       (pending_words)
   );

   always #5 clock = ~clock;

   // result side pacing; a hold request parks rsp_ready low for a long stretch once
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         seen_real_length  <= rsp_real_length;
         seen_struct_count <= rsp_struct_count;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [REG_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_table_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [7:0] random_type();
      logic [7:0] kind;
      do kind = 8'($urandom_range(0, 255)); while (kind == END_TYPE);
      return kind;
   endfunction

   // one structure; a garbled one has a random string area that ends at the
   // first double zero, wherever it happens to fall
   task automatic send_structure(input logic [7:0] kind, input bit garbled);
      int unsigned len;
      int unsigned n_str;
      int unsigned n_chr;
      int unsigned i;
      bit          prev_zero;
      logic [7:0]  b;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      send_byte(kind);
      send_byte(8'(len));
      for (i = 2; i < len; i++)
         send_byte(8'($urandom_range(0, 255)));
      if (garbled) begin
         prev_zero = 1'b0;
         i = 0;
         forever begin
            b = (i >= 48 || $urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_byte(b);
            if (prev_zero && b == 8'h00)
               break;
            prev_zero = (b == 8'h00);
            i++;
         end
      end else begin
         n_str = $urandom_range(0, 3);
         for (i = 0; i < n_str; i++) begin
            n_chr = $urandom_range(1, 10);
            repeat (n_chr) send_byte(8'($urandom_range(1, 255)));
            send_byte(8'h00);
         end
         if (n_str == 0)
            send_byte(8'h00);
         send_byte(8'h00);
      end
      structs_sent++;
   endtask

   initial begin
      walk_ending_type ending;
      int unsigned     mode;
      int unsigned     phase_start;
      int unsigned     r;
      int unsigned     k;
      int unsigned     eff;
      logic [7:0]      len_byte;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_reg(REG_TBL_LEN, 16'hFFFF);
      write_reg(REG_DECLARED_STRUCTS, 16'hFFFF);

      foreach (opening_table[i])
         send_byte(opening_table[i]);
      structs_sent = 4;
      drain();

      for (mode = 0; mode < 5; mode++) begin
         case (mode)
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            3: begin send_idle_pct = 36; recv_stall_pct = 36; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (mode == 4)
            hold_request = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES)
            send_structure(random_type(), $urandom_range(0, 4) == 0);
         drain();
         // keep the walk going with margin past the remaining stimulus
         write_reg(REG_TBL_LEN, 16'($urandom_range(bytes_sent + 1500, 65535)));
         write_reg(REG_DECLARED_STRUCTS, 16'($urandom_range(structs_sent + 500, 65535)));
      end

      send_idle_pct  = 36;
      recv_stall_pct = 36;
      ending = walk_ending_type'($urandom_range(0, 5));
      case (ending)
         END_BY_MARKER: begin
            send_structure(END_TYPE, 1'b0);
         end
         END_BY_COUNT: begin
            write_reg(REG_DECLARED_STRUCTS, 16'(structs_sent + $urandom_range(0, 2)));
            repeat (3) send_structure(random_type(), 1'b0);
         end
         END_BY_ZERO_COUNT: begin
            write_reg(REG_DECLARED_STRUCTS, 16'h0000);
            send_structure(random_type(), 1'b0);
         end
         END_BY_SHORT_TABLE: begin
            r = $urandom_range(0, 1) ? 0 : bytes_sent - $urandom_range(1, 50);
            write_reg(REG_TBL_LEN, 16'(r));
            send_structure(random_type(), 1'b0);
         end
         END_BY_BODY: begin
            r = $urandom_range(0, 20);
            write_reg(REG_TBL_LEN, 16'(bytes_sent + 2 + r));
            send_byte(random_type());
            send_byte(8'(2 + r + $urandom_range(0, 30)));
         end
         default: begin
            // string area with no double zero runs into the table end
            len_byte = 8'($urandom_range(0, 20));
            eff = (len_byte < 8'd2) ? 2 : len_byte;
            k = $urandom_range(1, 20);
            write_reg(REG_TBL_LEN, 16'(bytes_sent + eff + k));
            send_byte(random_type());
            send_byte(len_byte);
            repeat (eff - 2) send_byte(8'($urandom_range(0, 255)));
            repeat (k + 3) send_byte(8'($urandom_range(1, 255)));
         end
      endcase

      // walk is over: bytes are ignored, warnings follow the registers
      repeat (8) send_byte(8'($urandom_range(0, 255)));
      drain();
      write_reg(REG_TBL_LEN, 16'h0000);
      write_reg(REG_DECLARED_STRUCTS, 16'h0000);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      drain();
      write_reg(REG_TBL_LEN, seen_real_length[REG_WIDTH-1:0]);
      write_reg(REG_DECLARED_STRUCTS, seen_struct_count);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      drain();

      if (mismatch_count == 0 && pending_words == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/stlw_pkg.sv
rtl/core/stlw_walker.sv
rtl/core/structure_table_length_walker.sv
tb/structure_table_length_walker_checker.sv
tb/structure_table_length_walker_tb.sv
